// ===== sv/circular_queue_core_assert.svh =====
// Assertion helpers shared by the queue RTL.
// All are clocked on aclk and held off while aresetn is low.
`ifndef CIRCULAR_QUEUE_CORE_ASSERT_SVH
`define CIRCULAR_QUEUE_CORE_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define CQC_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("queue invariant violated");

// Same-cycle implication.
`define CQC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("queue implication violated");

// Next-cycle implication.
`define CQC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("queue next-cycle check violated");

`endif

// ===== sv/cqc_pkg.sv =====
package cqc_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int VAL_W    = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 40;   // 34 bits of fields, padded to bytes
    localparam int M_DATA_W = 112;  // 105 bits of fields, padded to bytes

    typedef enum logic [ACT_W-1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3   // behaves as a query
    } cqc_action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } cqc_status_t;

    // per-cell control, driven from the top level
    typedef struct packed {
        logic shift;   // take the neighbour's word (dequeue)
        logic load;    // take the incoming word (enqueue into this cell)
    } cqc_cell_ctl_t;

endpackage

// ===== sv/cqc_cell.sv =====
// One storage cell of the shifting queue row.
module cqc_cell (
    input  logic                              aclk,
    input  cqc_pkg::cqc_cell_ctl_t            ctl,
    input  logic signed [cqc_pkg::VAL_W-1:0]  shift_in,   // from the next-younger cell
    input  logic signed [cqc_pkg::VAL_W-1:0]  load_data,
    output logic signed [cqc_pkg::VAL_W-1:0]  data_out
);

    logic signed [cqc_pkg::VAL_W-1:0] data_reg;
    logic signed [cqc_pkg::VAL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift) begin
            data_next = shift_in;
        end else if (ctl.load) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== sv/circular_queue_core.sv =====
// FIFO queue of signed 32-bit words, DEPTH entries deep. Each input beat
// carries an action (enqueue, dequeue or query) and a value; each accepted
// beat yields exactly one result beat with the status, the word taken out
// (dequeue only), and the front word, rear word, occupancy and empty/full
// flags as they stand after the action. Enqueue when full or dequeue when
// empty changes nothing and returns a rejected status. Storage is a row of
// DEPTH cells with the oldest word always in cell 0: a dequeue shifts the
// whole row one cell towards the front, an enqueue writes the cell picked by
// the occupancy counter. One beat is taken per clock while the receiver keeps
// up; its result sits in the output register from the next cycle. A new beat
// is let in only when that register is empty or is being emptied at the same
// edge, so a stalled receiver holds off the input after one beat. Throughput
// is therefore one beat per cycle with the receiver ready.
module circular_queue_core #(
    parameter int DEPTH = cqc_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] action, [33:2] value, [39:34] zero
    input  logic [cqc_pkg::S_DATA_W-1:0]  s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [33:2] taken_value, [65:34] front_value,
    // [97:66] rear_value, [102:98] occupancy, [103] is_empty,
    // [104] is_full, [111:105] zero
    output logic [cqc_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PAD_W = cqc_pkg::M_DATA_W - (cqc_pkg::STAT_W + 3*cqc_pkg::VAL_W
                                                + cqc_pkg::OCC_W + 2);

    // ---------------------------------------------------------------
    // input beat decode
    // ---------------------------------------------------------------
    cqc_pkg::cqc_action_t              act;
    logic signed [cqc_pkg::VAL_W-1:0]  in_val;
    logic                              s_acc;

    assign act    = cqc_pkg::cqc_action_t'(s_tdata[cqc_pkg::ACT_W-1:0]);
    assign in_val = s_tdata[cqc_pkg::ACT_W +: cqc_pkg::VAL_W];
    assign s_acc  = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // occupancy and rear word
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic signed [cqc_pkg::VAL_W-1:0]  rear_reg, rear_next;
    logic                              q_empty, q_full, enq_ok, deq_ok;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign enq_ok  = s_acc && (act == cqc_pkg::ACT_ENQ) && !q_full;
    assign deq_ok  = s_acc && (act == cqc_pkg::ACT_DEQ) && !q_empty;

    always_comb begin
        count_next = count_reg;
        rear_next  = rear_reg;
        if (enq_ok) begin
            count_next = count_reg + CNT_W'(1);
            rear_next  = in_val;
        end else if (deq_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // payload only: meaningless while empty, masked on output
    always_ff @(posedge aclk) begin
        rear_reg <= rear_next;
    end

    // ---------------------------------------------------------------
    // cell row: cell 0 holds the oldest word
    // ---------------------------------------------------------------
    logic signed [cqc_pkg::VAL_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cqc_pkg::cqc_cell_ctl_t            ctl;
        logic signed [cqc_pkg::VAL_W-1:0]  nb;

        assign ctl.shift = deq_ok;
        assign ctl.load  = enq_ok && (count_reg[IDX_W-1:0] == IDX_W'(i));

        if (i == DEPTH - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_data[i+1];
        end

        cqc_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .shift_in  (nb),
            .load_data (in_val),
            .data_out  (cell_data[i])
        );
    end

    // ---------------------------------------------------------------
    // result for the beat being accepted
    // ---------------------------------------------------------------
    cqc_pkg::cqc_status_t              res_status;
    logic signed [cqc_pkg::VAL_W-1:0]  res_taken, res_front, res_rear;

    always_comb begin
        res_status = cqc_pkg::ST_OK;
        if ((act == cqc_pkg::ACT_ENQ) && q_full) begin
            res_status = cqc_pkg::ST_FULL;
        end else if ((act == cqc_pkg::ACT_DEQ) && q_empty) begin
            res_status = cqc_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        res_taken = deq_ok ? cell_data[0] : '0;
        if (enq_ok && q_empty) begin
            res_front = in_val;
        end else if (deq_ok) begin
            res_front = (count_reg > CNT_W'(1)) ? cell_data[1] : '0;
        end else begin
            res_front = q_empty ? '0 : cell_data[0];
        end
        res_rear = (count_next == '0) ? '0 : rear_next;
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic                          m_valid_reg, m_valid_next;
    logic [cqc_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_acc) begin
            m_valid_next = 1'b1;
            m_data_next  = {PAD_W'(0),
                            (count_next == CNT_W'(DEPTH)),
                            (count_next == '0),
                            cqc_pkg::OCC_W'(count_next),
                            res_rear,
                            res_front,
                            res_taken,
                            res_status};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
`include "circular_queue_core_assert.svh"

    `CQC_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `CQC_ASSERT_NEXT(a_enq_counts, enq_ok, count_reg == $past(count_reg) + CNT_W'(1))
    `CQC_ASSERT_NEXT(a_deq_counts, deq_ok, count_reg == $past(count_reg) - CNT_W'(1))
    `CQC_ASSERT_IMPL(a_flags_agree, m_tvalid, m_tdata[103] == (m_tdata[102:98] == '0) || (DEPTH > 31))

endmodule

// ===== dv/circular_queue_core_chk.sv =====
module circular_queue_core_chk
    import cqc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [1:0] action, [33:2] value, [39:34] zero
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [33:2] taken_value, [65:34] front_value,
    // [97:66] rear_value, [102:98] occupancy, [103] is_empty,
    // [104] is_full, [111:105] zero
    input  logic [M_DATA_W-1:0]  m_tdata,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cqc_status_t        status;
        logic [VAL_W-1:0]   taken;
        logic [VAL_W-1:0]   front;
        logic [VAL_W-1:0]   rear;
        logic [OCC_W-1:0]   occ;
        logic               is_empty;
        logic               is_full;
    } queue_view_t;

    // Shadow ring: oldest at head_pos, newest at tail_pos.
    logic [VAL_W-1:0] ring [DEPTH];
    int               head_pos;
    int               tail_pos;
    bit               drained;
    queue_view_t      views_due [$];

    function automatic int stored_words();
        if (drained)
            return 0;
        return ((tail_pos + DEPTH - head_pos) % DEPTH) + 1;
    endfunction

    function automatic queue_view_t apply_action(cqc_action_t act, logic [VAL_W-1:0] word);
        queue_view_t v;
        int          fill;
        v = '0;
        v.status = ST_OK;
        fill = stored_words();
        case (act)
            ACT_ENQ: begin
                if (fill >= DEPTH) begin
                    v.status = ST_FULL;
                end else if (drained) begin
                    head_pos = 0;
                    tail_pos = 0;
                    ring[0] = word;
                    drained = 1'b0;
                end else begin
                    tail_pos = (tail_pos + 1) % DEPTH;
                    ring[tail_pos] = word;
                end
            end
            ACT_DEQ: begin
                if (drained) begin
                    v.status = ST_EMPTY;
                end else begin
                    v.taken = ring[head_pos];
                    // last word out: back to the reset layout
                    if (head_pos == tail_pos) begin
                        head_pos = 0;
                        tail_pos = 0;
                        drained = 1'b1;
                    end else begin
                        head_pos = (head_pos + 1) % DEPTH;
                    end
                end
            end
            default: ;  // query and the spare code change nothing
        endcase
        fill = stored_words();
        v.front    = drained ? '0 : ring[head_pos];
        v.rear     = drained ? '0 : ring[tail_pos];
        v.occ      = fill[OCC_W-1:0];
        v.is_empty = drained;
        v.is_full  = (fill >= DEPTH);
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("%0t ns: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_result(logic [M_DATA_W-1:0] beat);
        queue_view_t want;
        if (views_due.size() == 0) begin
            report_mismatch("result beat with nothing due, status", VAL_W'(beat[1:0]), '0);
            return;
        end
        want = views_due.pop_front();
        if (beat[1:0] !== want.status)
            report_mismatch("status", VAL_W'(beat[1:0]), VAL_W'(want.status));
        if (beat[33:2] !== want.taken)
            report_mismatch("taken_value", beat[33:2], want.taken);
        if (beat[65:34] !== want.front)
            report_mismatch("front_value", beat[65:34], want.front);
        if (beat[97:66] !== want.rear)
            report_mismatch("rear_value", beat[97:66], want.rear);
        if (beat[102:98] !== want.occ)
            report_mismatch("occupancy", VAL_W'(beat[102:98]), VAL_W'(want.occ));
        if (beat[103] !== want.is_empty)
            report_mismatch("is_empty", VAL_W'(beat[103]), VAL_W'(want.is_empty));
        if (beat[104] !== want.is_full)
            report_mismatch("is_full", VAL_W'(beat[104]), VAL_W'(want.is_full));
    endtask

    // Result side first: a result taken at this edge belongs to an older beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_pos = 0;
            tail_pos = 0;
            drained  = 1'b1;
            views_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                views_due.push_back(apply_action(cqc_action_t'(s_tdata[1:0]),
                                                 s_tdata[33:2]));
        end
        pending <= views_due.size();
    end

endmodule

// ===== dv/circular_queue_core_tb.sv =====
module circular_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqc_pkg::*;

    // Random part length and the tail of it that runs with no idling.
    localparam int RANDOM_BEATS   = 1100;
    localparam int CALM_BEATS     = 150;
    // Longest receiver hold-off, used once to back the block up.
    localparam int SQUEEZE_CYCLES = 64;
    // Cycles with no beat on either side before the run is declared hung.
    // Slowest correct gap is the squeeze plus a sender burst, far below this.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] action, [33:2] value, [39:34] zero
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [33:2] taken_value, [65:34] front_value,
    // [97:66] rear_value, [102:98] occupancy, [103] is_empty,
    // [104] is_full, [111:105] zero
    logic [M_DATA_W-1:0]  m_tdata;

    int errors;
    int pending;

    // calm: no more idling on either side; squeeze_req: ask the receiver
    // for its long hold-off.
    bit calm        = 1'b0;
    bit squeeze_req = 1'b0;

    circular_queue_core #(
        .DEPTH(DEPTH_DEF)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    circular_queue_core_chk #(
        .DEPTH(DEPTH_DEF)
    ) watch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Offer one beat and hold it until the block takes it. Returns in the
    // time step of the accepting edge, so the next beat can follow at once
    // without valid dropping.
    task automatic send_beat(cqc_action_t act, logic [VAL_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - VAL_W - ACT_W){1'b0}}, word, act};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Sender idles in short bursts now and then, never once calm.
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge aclk);
        end
    endtask

    // Mostly random words, with the extremes turning up often.
    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: bursts of ready and of stall, one long squeeze on request.
    initial begin
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES)
                    @(posedge aclk);
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9))
                    @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16))
                    @(posedge aclk);
            end
        end
    end

    // Watchdog: any beat on either side restarts the count.
    initial begin
        int quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("circular_queue_core_tb: errors");
        $finish;
    end

    initial begin
        cqc_action_t act;
        int          enq_pct;
        int          roll;

        enq_pct = 50;
        repeat (5)
            @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // Empty queue: query, dequeue underflow, spare code with all ones.
        send_beat(ACT_QUERY, 32'h1234_5678);
        maybe_idle();
        send_beat(ACT_DEQ, 32'hdead_beef);
        send_beat(ACT_NONE, 32'hffff_ffff);
        // Single word in and out: last removal returns to the reset layout.
        send_beat(ACT_ENQ, 32'h8000_0000);
        maybe_idle();
        send_beat(ACT_DEQ, 32'h0);
        // Fill to the brim, extremes first.
        for (int k = 0; k < DEPTH_DEF; k++) begin
            maybe_idle();
            case (k)
                0:       send_beat(ACT_ENQ, 32'h7fff_ffff);
                1:       send_beat(ACT_ENQ, 32'h0000_0000);
                2:       send_beat(ACT_ENQ, 32'hffff_ffff);
                3:       send_beat(ACT_ENQ, 32'h8000_0000);
                default: send_beat(ACT_ENQ, $urandom());
            endcase
        end
        // Overflow is refused; then one out and one in so the tail wraps.
        send_beat(ACT_ENQ, 32'h7fff_ffff);
        send_beat(ACT_DEQ, 32'h0);
        maybe_idle();
        send_beat(ACT_ENQ, 32'h5a5a_a5a5);
        send_beat(ACT_NONE, 32'h0f0f_0f0f);

        // ---- random part ----
        // Runs of 40 beats lean towards filling, draining or balance so the
        // queue sweeps its whole range, wraps often and hits both limits.
        squeeze_req = 1'b1;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 15;
                    1:       enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            if (i == RANDOM_BEATS - CALM_BEATS)
                calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                act = ACT_QUERY;
            else if (roll < 8)
                act = ACT_NONE;
            else if ($urandom_range(0, 99) < enq_pct)
                act = ACT_ENQ;
            else
                act = ACT_DEQ;
            maybe_idle();
            send_beat(act, pick_word());
        end

        // ---- drain ----
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        // a little slack for stray beats
        repeat (8)
            @(posedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("circular_queue_core_tb: clean");
        end else begin
            $display("circular_queue_core_tb: errors");
        end
        $finish;
    end

endmodule
